// ----- hw/rtl/ovs_pkg.sv -----
// ----------------------------------------------------------------------------
// Open-loop voltage sequencer package
// Shared codes, configuration and result types, and the align table lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package ovs_pkg;

    localparam int unsigned OVS_MAX_POSITIONS = 4;

    // Request function codes
    localparam logic [1:0] FUNC_TICK   = 2'd0;
    localparam logic [1:0] FUNC_ALIGN  = 2'd1;
    localparam logic [1:0] FUNC_ROTATE = 2'd2;

    // Drive command codes
    localparam logic [1:0] DRIVE_HOLD  = 2'd0;
    localparam logic [1:0] DRIVE_ZERO  = 2'd1;
    localparam logic [1:0] DRIVE_APPLY = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_NUM_POSITIONS = 3'd0;
    localparam logic [2:0] CFG_TABLE_LOW     = 3'd1;
    localparam logic [2:0] CFG_TABLE_HIGH    = 3'd2;
    localparam logic [2:0] CFG_ALIGN_VOLTAGE = 3'd3;
    localparam logic [2:0] CFG_ROT_VOLTAGE   = 3'd4;
    localparam logic [2:0] CFG_ROT_SPEED     = 3'd5;
    localparam logic [2:0] CFG_ROT_DURATION  = 3'd6;
    localparam logic [2:0] CFG_ROT_START     = 3'd7;

    typedef enum logic [2:0] {
        MODE_IDLE   = 3'b001,
        MODE_ALIGN  = 3'b010,
        MODE_ROTATE = 3'b100
    } mode_t;

    typedef struct packed {
        logic [2:0]         num_align_positions;
        logic [63:0]        align_table_low;
        logic [63:0]        align_table_high;
        logic signed [15:0] align_voltage;
        logic signed [15:0] rotate_voltage;
        logic signed [31:0] rotate_speed;
        logic [31:0]        rotate_duration;
        logic [15:0]        rotate_start_angle;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         drive;
        logic signed [15:0] q_voltage;
        logic [15:0]        drive_angle;
        logic signed [63:0] total_angle;
        logic               finished;
    } res_t;

    // One align position: angle in bits 15..0, duration in bits 31..16.
    function automatic logic [31:0] pos_word(input logic [63:0] lo,
                                             input logic [63:0] hi,
                                             input logic [1:0]  p);
        logic [63:0] w;
        w = p[1] ? hi : lo;
        return p[0] ? w[63:32] : w[31:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/ovs_cfg.sv -----
// ----------------------------------------------------------------------------
// Open-loop voltage sequencer configuration registers
// Write-only register file loaded through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module ovs_cfg
    import ovs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_NUM_POSITIONS: cfg_next.num_align_positions = cfg_data[2:0];
                CFG_TABLE_LOW:     cfg_next.align_table_low     = cfg_data;
                CFG_TABLE_HIGH:    cfg_next.align_table_high    = cfg_data;
                CFG_ALIGN_VOLTAGE: cfg_next.align_voltage       = cfg_data[15:0];
                CFG_ROT_VOLTAGE:   cfg_next.rotate_voltage      = cfg_data[15:0];
                CFG_ROT_SPEED:     cfg_next.rotate_speed        = cfg_data[31:0];
                CFG_ROT_DURATION:  cfg_next.rotate_duration     = cfg_data[31:0];
                CFG_ROT_START:     cfg_next.rotate_start_angle  = cfg_data[15:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/ovs_core.sv -----
// ----------------------------------------------------------------------------
// Open-loop voltage sequencer core
// Sequencer state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module ovs_core
    import ovs_pkg::*;
#(
    parameter int unsigned MAX_POSITIONS = OVS_MAX_POSITIONS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        fire,
    input  wire logic [1:0]  func,
    input  wire logic [15:0] dt,
    input  wire cfg_t        cfg,
    output res_t             res
);

    mode_t              mode_reg,        mode_next;
    logic [31:0]        elapsed_reg,     elapsed_next;
    logic [2:0]         pos_idx_reg,     pos_idx_next;
    logic [31:0]        phase_reg,       phase_next;
    logic [63:0]        unwrapped_reg,   unwrapped_next;
    logic [2:0]         lat_count_reg,   lat_count_next;
    logic signed [15:0] lat_align_v_reg, lat_align_v_next;
    logic signed [15:0] lat_rot_v_reg,   lat_rot_v_next;
    logic signed [31:0] lat_speed_reg,   lat_speed_next;
    logic [31:0]        lat_duration_reg, lat_duration_next;

    logic [32:0]        elapsed_sum;
    logic [31:0]        elapsed_sat;
    logic [2:0]         clamp_count;
    logic [31:0]        cur_word;
    logic [2:0]         adv_idx;
    logic [31:0]        new_word;
    logic signed [16:0] dt_signed;
    logic signed [48:0] product;
    logic [63:0]        delta;

    assign elapsed_sum = {1'b0, elapsed_reg} + {17'd0, dt};
    assign elapsed_sat = elapsed_sum[32] ? 32'hFFFF_FFFF : elapsed_sum[31:0];
    assign clamp_count = (cfg.num_align_positions > 3'(MAX_POSITIONS))
                       ? 3'(MAX_POSITIONS) : cfg.num_align_positions;
    assign cur_word  = pos_word(cfg.align_table_low, cfg.align_table_high,
                                pos_idx_reg[1:0]);
    // Position that an align tick lands on once the current hold time is checked.
    assign adv_idx   = (elapsed_sat >= {16'd0, cur_word[31:16]})
                     ? pos_idx_reg + 3'd1 : pos_idx_reg;
    assign new_word  = pos_word(cfg.align_table_low, cfg.align_table_high,
                                adv_idx[1:0]);
    assign dt_signed = signed'({1'b0, dt});
    assign product   = lat_speed_reg * dt_signed;
    assign delta     = {{15{product[48]}}, product};

    always_comb
    begin
        mode_next         = mode_reg;
        elapsed_next      = elapsed_reg;
        pos_idx_next      = pos_idx_reg;
        phase_next        = phase_reg;
        unwrapped_next    = unwrapped_reg;
        lat_count_next    = lat_count_reg;
        lat_align_v_next  = lat_align_v_reg;
        lat_rot_v_next    = lat_rot_v_reg;
        lat_speed_next    = lat_speed_reg;
        lat_duration_next = lat_duration_reg;
        res.drive         = DRIVE_HOLD;
        res.q_voltage     = '0;
        res.drive_angle   = '0;

        case (func)
            FUNC_ALIGN:
            begin
                // A start with no positions configured leaves everything as is.
                if (cfg.num_align_positions != 3'd0)
                begin
                    lat_count_next   = clamp_count;
                    lat_align_v_next = cfg.align_voltage;
                    pos_idx_next     = '0;
                    elapsed_next     = '0;
                    mode_next        = MODE_ALIGN;
                end
            end
            FUNC_ROTATE:
            begin
                lat_rot_v_next    = cfg.rotate_voltage;
                lat_speed_next    = cfg.rotate_speed;
                lat_duration_next = cfg.rotate_duration;
                elapsed_next      = '0;
                phase_next        = {cfg.rotate_start_angle, 16'h0000};
                unwrapped_next    = {32'd0, cfg.rotate_start_angle, 16'h0000};
                mode_next         = MODE_ROTATE;
            end
            FUNC_TICK:
            begin
                if (mode_reg == MODE_ALIGN && pos_idx_reg < lat_count_reg)
                begin
                    elapsed_next = elapsed_sat;
                    if (elapsed_sat >= {16'd0, cur_word[31:16]})
                    begin
                        elapsed_next = '0;
                        pos_idx_next = pos_idx_reg + 3'd1;
                    end
                    if (pos_idx_next >= lat_count_reg)
                    begin
                        res.drive = DRIVE_ZERO;
                    end
                    else
                    begin
                        res.drive       = DRIVE_APPLY;
                        res.q_voltage   = lat_align_v_reg;
                        res.drive_angle = new_word[15:0];
                    end
                end
                else if (mode_reg == MODE_ROTATE)
                begin
                    elapsed_next = elapsed_sat;
                    if (elapsed_sat >= lat_duration_reg)
                    begin
                        res.drive = DRIVE_ZERO;
                    end
                    else
                    begin
                        phase_next      = phase_reg + delta[31:0];
                        unwrapped_next  = unwrapped_reg + delta;
                        res.drive       = DRIVE_APPLY;
                        res.q_voltage   = lat_rot_v_reg;
                        res.drive_angle = phase_next[31:16];
                    end
                end
            end
            default:
            begin
                mode_next = mode_reg;
            end
        endcase

        res.total_angle = signed'(unwrapped_next);
        case (mode_next)
            MODE_ALIGN:  res.finished = (pos_idx_next >= lat_count_next);
            MODE_ROTATE: res.finished = (elapsed_next >= lat_duration_next);
            default:     res.finished = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_IDLE;
            elapsed_reg      <= '0;
            pos_idx_reg      <= '0;
            phase_reg        <= '0;
            unwrapped_reg    <= '0;
            lat_count_reg    <= '0;
            lat_align_v_reg  <= '0;
            lat_rot_v_reg    <= '0;
            lat_speed_reg    <= '0;
            lat_duration_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg         <= mode_next;
            elapsed_reg      <= elapsed_next;
            pos_idx_reg      <= pos_idx_next;
            phase_reg        <= phase_next;
            unwrapped_reg    <= unwrapped_next;
            lat_count_reg    <= lat_count_next;
            lat_align_v_reg  <= lat_align_v_next;
            lat_rot_v_reg    <= lat_rot_v_next;
            lat_speed_reg    <= lat_speed_next;
            lat_duration_reg <= lat_duration_next;
        end
    end

    // The position index never runs past the latched count while aligning.
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_ALIGN |-> pos_idx_reg <= lat_count_reg)
        else $error("align position index beyond latched count");

    // The latched count stays within the configured maximum.
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        lat_count_reg <= 3'(MAX_POSITIONS))
        else $error("latched align count above maximum");

    // Applying voltage always means the sequence is still running.
    a_apply_busy: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.drive == DRIVE_APPLY |-> !res.finished)
        else $error("voltage applied on a finished sequence");

    // A rotation start always lands in rotate mode.
    a_rot_start: assert property (@(posedge clk) disable iff (!rst_n)
        fire && func == FUNC_ROTATE |=> mode_reg == MODE_ROTATE)
        else $error("rotation start did not enter rotate mode");

    // The total angle only moves when a request is processed.
    a_angle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(unwrapped_reg))
        else $error("total angle changed without a request");

endmodule

`default_nettype wire

// ----- hw/rtl/open_loop_voltage_sequencer.sv -----
// ----------------------------------------------------------------------------
// Open-loop voltage sequencer
// Align and ramp sequencer for open-loop motor drive.
//
//   Channel  Direction  Handshake              Payload
//   cfg      in         cfg_wr_en              cfg_index, cfg_data
//   in       in         in_valid / in_stall    func, dt
//   out      out        out_valid / out_stall  drive, q_voltage, drive_angle,
//                                              total_angle, finished
//
// One request is taken every cycle while in_stall is low; its result moves
// from the input register into the output register when that one is free or
// being emptied. The sequencer state advances in that same step, so
// back-to-back requests each see the state left by the one before.
// Reset clears the configuration, the sequencer state and both valid flags.
// A stall on the output holds the result; in_stall is high while both the
// input and output registers are full and the output is stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module open_loop_voltage_sequencer
    import ovs_pkg::*;
#(
    parameter int unsigned MAX_POSITIONS = OVS_MAX_POSITIONS
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    input  wire logic               in_valid,
    output      logic               in_stall,
    input  wire logic [1:0]         func,
    input  wire logic [15:0]        dt,
    output      logic               out_valid,
    input  wire logic               out_stall,
    output      logic [1:0]         drive,
    output      logic signed [15:0] q_voltage,
    output      logic [15:0]        drive_angle,
    output      logic signed [63:0] total_angle,
    output      logic               finished
);

    cfg_t        cfg;
    res_t        res;
    res_t        res_reg;
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_func_reg;
    logic [15:0] s1_dt_reg;
    logic        out_valid_reg, out_valid_next;
    logic        in_accept;
    logic        fire;

    ovs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ovs_core #(
        .MAX_POSITIONS (MAX_POSITIONS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .func  (s1_func_reg),
        .dt    (s1_dt_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // The captured request moves on whenever the output register is free or
    // is being emptied in this cycle.
    assign fire      = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign s1_valid_next  = in_accept || (s1_valid_reg && !fire);
    assign out_valid_next = fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_func_reg <= func;
            s1_dt_reg   <= dt;
        end
        if (fire)
        begin
            res_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive       = res_reg.drive;
    assign q_voltage   = res_reg.q_voltage;
    assign drive_angle = res_reg.drive_angle;
    assign total_angle = res_reg.total_angle;
    assign finished    = res_reg.finished;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Open-loop voltage sequencer testbench
// Sends align, rotate, tick and unused-code requests with random gaps and output stalls,
// predicts every result in step with the block and compares each field.
// ----------------------------------------------------------------------------

module tb
    import ovs_pkg::*;
;

    // The block ignores this function code.
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [2:0]         cfg_index;
    logic [63:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         func;
    logic [15:0]        dt;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         drive;
    logic signed [15:0] q_voltage;
    logic [15:0]        drive_angle;
    logic signed [63:0] total_angle;
    logic               finished;

    open_loop_voltage_sequencer dut (.*);

    typedef struct {
        bit          cfg;
        logic [2:0]  idx;
        logic [63:0] data;
        logic [1:0]  f;
        logic [15:0] d;
        bit          typed;
        res_t        want;
    } row_t;

    row_t        plan[$];
    res_t        pending_results[$];
    int unsigned fault_count = 0;
    int unsigned result_count = 0;
    int unsigned cycle_no = 0;

    // Register copies
    logic [2:0]  reg_count;
    logic [63:0] reg_table_lo;
    logic [63:0] reg_table_hi;
    logic [15:0] reg_align_v;
    logic [15:0] reg_rot_v;
    logic [31:0] reg_speed;
    logic [31:0] reg_duration;
    logic [15:0] reg_start;

    // Sequencer state and values latched at a start
    mode_t              seq_mode;
    logic [31:0]        seq_elapsed;
    logic [2:0]         seq_pos;
    logic [31:0]        seq_phase;
    logic signed [63:0] seq_unwrapped;
    logic [2:0]         held_count;
    logic [15:0]        held_align_v;
    logic [15:0]        held_rot_v;
    logic [31:0]        held_speed;
    logic [31:0]        held_duration;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) cycle_no <= cycle_no + 1;

    initial
    begin : watchdog
        #2_000_000;
        $display("FAIL open_loop_voltage_sequencer");
        $finish;
    end

    function automatic void clear_sequencer();
        reg_count = '0;
        reg_table_lo = '0;
        reg_table_hi = '0;
        reg_align_v = '0;
        reg_rot_v = '0;
        reg_speed = '0;
        reg_duration = '0;
        reg_start = '0;
        seq_mode = MODE_IDLE;
        seq_elapsed = '0;
        seq_pos = '0;
        seq_phase = '0;
        seq_unwrapped = '0;
        held_count = '0;
        held_align_v = '0;
        held_rot_v = '0;
        held_speed = '0;
        held_duration = '0;
    endfunction

    function automatic void store_register(input logic [2:0] idx, input logic [63:0] data);
        case (idx)
            CFG_NUM_POSITIONS: reg_count = data[2:0];
            CFG_TABLE_LOW:     reg_table_lo = data;
            CFG_TABLE_HIGH:    reg_table_hi = data;
            CFG_ALIGN_VOLTAGE: reg_align_v = data[15:0];
            CFG_ROT_VOLTAGE:   reg_rot_v = data[15:0];
            CFG_ROT_SPEED:     reg_speed = data[31:0];
            CFG_ROT_DURATION:  reg_duration = data[31:0];
            CFG_ROT_START:     reg_start = data[15:0];
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] align_entry(input logic [1:0] p);
        logic [127:0] both;
        both = {reg_table_hi, reg_table_lo};
        return both[p * 32 +: 32];
    endfunction

    function automatic void add_time(input logic [15:0] d);
        logic [32:0] sum;
        sum = {1'b0, seq_elapsed} + {17'd0, d};
        seq_elapsed = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic res_t sequencer_step(input logic [1:0] f, input logic [15:0] d);
        res_t               r;
        logic [31:0]        entry;
        logic signed [63:0] delta;
        r = '0;
        case (f)
            FUNC_ALIGN:
                if (reg_count != 0)
                begin
                    held_count = (reg_count > OVS_MAX_POSITIONS) ?
                                 3'(OVS_MAX_POSITIONS) : reg_count;
                    held_align_v = reg_align_v;
                    seq_pos = '0;
                    seq_elapsed = '0;
                    seq_mode = MODE_ALIGN;
                end
            FUNC_ROTATE:
            begin
                held_rot_v = reg_rot_v;
                held_speed = reg_speed;
                held_duration = reg_duration;
                seq_elapsed = '0;
                seq_phase = {reg_start, 16'd0};
                seq_unwrapped = {32'd0, reg_start, 16'd0};
                seq_mode = MODE_ROTATE;
            end
            FUNC_TICK:
                if (seq_mode == MODE_ALIGN && seq_pos < held_count)
                begin
                    add_time(d);
                    entry = align_entry(seq_pos[1:0]);
                    if (seq_elapsed >= {16'd0, entry[31:16]})
                    begin
                        seq_elapsed = '0;
                        seq_pos = seq_pos + 3'd1;
                    end
                    if (seq_pos >= held_count)
                        r.drive = DRIVE_ZERO;
                    else
                    begin
                        entry = align_entry(seq_pos[1:0]);
                        r.drive = DRIVE_APPLY;
                        r.q_voltage = held_align_v;
                        r.drive_angle = entry[15:0];
                    end
                end
                else if (seq_mode == MODE_ROTATE)
                begin
                    add_time(d);
                    if (seq_elapsed >= held_duration)
                        r.drive = DRIVE_ZERO;
                    else
                    begin
                        // Full 64-bit step, so a step of several turns wraps the phase fully.
                        delta = $signed({{32{held_speed[31]}}, held_speed}) *
                                $signed({48'd0, d});
                        seq_phase = seq_phase + delta[31:0];
                        seq_unwrapped = seq_unwrapped + delta;
                        r.drive = DRIVE_APPLY;
                        r.q_voltage = held_rot_v;
                        r.drive_angle = seq_phase[31:16];
                    end
                end
            default: ;
        endcase
        r.total_angle = seq_unwrapped;
        if (seq_mode == MODE_ALIGN)
            r.finished = (seq_pos >= held_count);
        else if (seq_mode == MODE_ROTATE)
            r.finished = (seq_elapsed >= held_duration);
        else
            r.finished = 1'b1;
        return r;
    endfunction

    function automatic res_t outcome(input logic [1:0] drv, input logic [15:0] q,
                                     input logic [15:0] ang, input logic [63:0] total,
                                     input logic fin);
        res_t r;
        r.drive = drv;
        r.q_voltage = q;
        r.drive_angle = ang;
        r.total_angle = total;
        r.finished = fin;
        return r;
    endfunction

    function automatic void add_cfg(input logic [2:0] idx, input logic [63:0] data);
        row_t row;
        row = '{cfg: 1'b1, idx: idx, data: data, f: '0, d: '0, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_req(input logic [1:0] f, input logic [15:0] d);
        row_t row;
        row = '{cfg: 1'b0, idx: '0, data: '0, f: f, d: d, typed: 1'b0, want: '0};
        plan.push_back(row);
    endfunction

    function automatic void add_typed(input logic [1:0] f, input logic [15:0] d,
                                      input res_t want);
        row_t row;
        row = '{cfg: 1'b0, idx: '0, data: '0, f: f, d: d, typed: 1'b1, want: want};
        plan.push_back(row);
    endfunction

    // Neither side inserts random gaps inside a recurring quiet window.
    function automatic bit quiet_window();
        return (cycle_no % 1024) >= 512 && (cycle_no % 1024) < 900;
    endfunction

    function automatic bit sender_idles();
        return !quiet_window() && ($urandom_range(0, 99) < 6);
    endfunction

    function automatic logic [2:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 3'd0;
            1: return 3'($urandom_range(5, 7));
            default: return 3'($urandom_range(1, 4));
        endcase
    endfunction

    function automatic logic [31:0] pick_position();
        logic [15:0] span;
        case ($urandom_range(0, 9))
            0: span = 16'd0;
            1: span = 16'($urandom);
            default: span = 16'($urandom_range(1, 40));
        endcase
        return {span, 16'($urandom)};
    endfunction

    function automatic logic [15:0] pick_voltage();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_speed();
        logic [31:0] mag;
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom;
            default:
            begin
                mag = $urandom_range(0, 4_000_000);
                return $urandom_range(0, 1) ? -mag : mag;
            end
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    function automatic logic [15:0] tick_dt(input int unsigned scale);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'($urandom);
        if (r < 12)
            return 16'd0;
        return 16'($urandom_range(0, scale));
    endfunction

    task automatic send_request(input logic [1:0] f, input logic [15:0] d,
                                output res_t predicted);
        while (sender_idles())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        dt <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted = sequencer_step(f, d);
    endtask

    task automatic offer(input logic [1:0] f, input logic [15:0] d);
        res_t predicted;
        send_request(f, d, predicted);
        pending_results.push_back(predicted);
    endtask

    // Registers are only written once every request has produced its result.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] data, input bit last);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        store_register(idx, data);
        if (last)
            cfg_wr_en <= 1'b0;
    endtask

    initial
    begin : receiver
        int unsigned rx_cycles;
        int unsigned hold_left;
        rx_cycles = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            rx_cycles++;
            // A long hold-off lets the block fill up and stall its input.
            if (rx_cycles % 1000 == 300)
                hold_left = 60;
            if (hold_left != 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= !quiet_window() && ($urandom_range(0, 99) < 6);
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.drive = drive;
            got.q_voltage = q_voltage;
            got.drive_angle = drive_angle;
            got.total_angle = total_angle;
            got.finished = finished;
            if (pending_results.size() == 0)
            begin
                if (fault_count < 10)
                    $display("result %0d arrived with no request waiting", result_count);
                fault_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.drive !== want.drive || got.q_voltage !== want.q_voltage ||
                    got.drive_angle !== want.drive_angle ||
                    got.total_angle !== want.total_angle ||
                    got.finished !== want.finished)
                begin
                    if (fault_count < 10)
                        $display({"result %0d mismatch (expected/actual): drive %0d/%0d ",
                                  "q %0d/%0d angle %h/%h total %h/%h finished %0d/%0d"},
                                 result_count, want.drive, got.drive,
                                 want.q_voltage, got.q_voltage,
                                 want.drive_angle, got.drive_angle,
                                 want.total_angle, got.total_angle,
                                 want.finished, got.finished);
                    fault_count++;
                end
            end
            result_count++;
        end
    end

    initial
    begin : stimulus
        res_t        predicted;
        int unsigned sent;
        int unsigned n;
        int unsigned j;
        int unsigned kind;
        int unsigned r;
        int unsigned k;
        logic [1:0]  f;
        logic [15:0] d;

        rst_n <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        func <= FUNC_TICK;
        dt <= '0;
        clear_sequencer();

        // Straight after reset: idle, nothing configured.
        add_typed(FUNC_TICK, 16'd0, outcome(DRIVE_HOLD, 16'd0, 16'd0, 64'd0, 1'b1));
        add_typed(FUNC_UNUSED, 16'hFFFF, outcome(DRIVE_HOLD, 16'd0, 16'd0, 64'd0, 1'b1));
        add_typed(FUNC_ALIGN, 16'h8001, outcome(DRIVE_HOLD, 16'd0, 16'd0, 64'd0, 1'b1));
        add_typed(FUNC_ROTATE, 16'd0, outcome(DRIVE_HOLD, 16'd0, 16'd0, 64'd0, 1'b1));
        add_typed(FUNC_TICK, 16'd1, outcome(DRIVE_ZERO, 16'd0, 16'd0, 64'd0, 1'b1));
        // Count above the maximum; the first position has zero duration.
        add_cfg(CFG_NUM_POSITIONS, 64'd7);
        add_cfg(CFG_TABLE_LOW, 64'hFFFF_FFFF_0000_0000);
        add_cfg(CFG_TABLE_HIGH, 64'h0001_8000_0003_1234);
        add_cfg(CFG_ALIGN_VOLTAGE, 64'h8000);
        add_req(FUNC_ALIGN, 16'd0);
        add_req(FUNC_TICK, 16'd0);
        add_req(FUNC_TICK, 16'hFFFF);
        add_req(FUNC_TICK, 16'd1);
        add_req(FUNC_TICK, 16'd2);
        add_typed(FUNC_TICK, 16'd5, outcome(DRIVE_ZERO, 16'd0, 16'd0, 64'd0, 1'b1));
        add_typed(FUNC_TICK, 16'd7, outcome(DRIVE_HOLD, 16'd0, 16'd0, 64'd0, 1'b1));
        add_cfg(CFG_ROT_VOLTAGE, 64'h7FFF);
        add_cfg(CFG_ROT_SPEED, 64'h7FFF_FFFF);
        add_cfg(CFG_ROT_DURATION, 64'hFFFF_FFFF);
        add_cfg(CFG_ROT_START, 64'hFFFF);
        add_cfg(CFG_ALIGN_VOLTAGE, 64'h7FFF);
        add_typed(FUNC_ROTATE, 16'd0,
                  outcome(DRIVE_HOLD, 16'd0, 16'd0, 64'h0000_0000_FFFF_0000, 1'b0));
        add_req(FUNC_TICK, 16'hFFFF);
        add_req(FUNC_TICK, 16'd0);
        add_req(FUNC_UNUSED, 16'h1234);
        add_req(FUNC_ALIGN, 16'hFFFF);
        add_req(FUNC_TICK, 16'd3);
        // Most negative speed; the rotation ends and stays frozen.
        add_cfg(CFG_ROT_SPEED, 64'h8000_0000);
        add_cfg(CFG_ROT_DURATION, 64'h1_0000);
        add_cfg(CFG_ROT_START, 64'd0);
        add_cfg(CFG_ROT_VOLTAGE, 64'h8000);
        add_req(FUNC_ROTATE, 16'h5555);
        add_req(FUNC_TICK, 16'hFFFF);
        add_req(FUNC_TICK, 16'd1);
        add_req(FUNC_TICK, 16'hAAAA);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < plan.size(); k++)
        begin
            if (plan[k].cfg)
            begin
                if (k == 0 || !plan[k - 1].cfg)
                    settle();
                write_reg(plan[k].idx, plan[k].data, k + 1 == plan.size() || !plan[k + 1].cfg);
            end
            else
            begin
                send_request(plan[k].f, plan[k].d, predicted);
                pending_results.push_back(plan[k].typed ? plan[k].want : predicted);
            end
        end

        // Random phases: fresh settings, then mostly well-formed sequences.
        sent = 0;
        while (sent < 750)
        begin
            settle();
            write_reg(CFG_NUM_POSITIONS, 64'(pick_count()), 1'b0);
            write_reg(CFG_TABLE_LOW, {pick_position(), pick_position()}, 1'b0);
            write_reg(CFG_TABLE_HIGH, {pick_position(), pick_position()}, 1'b0);
            write_reg(CFG_ALIGN_VOLTAGE, 64'(pick_voltage()), 1'b0);
            write_reg(CFG_ROT_VOLTAGE, 64'(pick_voltage()), 1'b0);
            write_reg(CFG_ROT_SPEED, 64'(pick_speed()), 1'b0);
            write_reg(CFG_ROT_DURATION, 64'(pick_duration()), 1'b0);
            write_reg(CFG_ROT_START, 64'($urandom_range(0, 65535)), 1'b1);
            kind = $urandom_range(0, 9);
            if (kind < 5)
                offer(FUNC_ALIGN, 16'($urandom));
            else if (kind < 9)
                offer(FUNC_ROTATE, 16'($urandom));
            sent++;
            n = $urandom_range(10, 40);
            for (j = 0; j < n; j++)
            begin
                r = $urandom_range(0, 99);
                d = 16'($urandom);
                if (kind == 9)
                    f = 2'($urandom);
                else if (r < 3)
                    f = FUNC_UNUSED;
                else if (r < 6)
                    f = (kind < 5) ? FUNC_ALIGN : FUNC_ROTATE;
                else if (r < 8)
                    f = (kind < 5) ? FUNC_ROTATE : FUNC_ALIGN;
                else
                begin
                    f = FUNC_TICK;
                    d = tick_dt((kind < 5) ? 15 : 120);
                end
                offer(f, d);
                if (f != FUNC_UNUSED)
                    sent++;
            end
        end

        in_valid <= 1'b0;
        for (k = 0; k < 5000 && pending_results.size() != 0; k++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        fault_count += pending_results.size();
        if (fault_count == 0)
            $display("PASS open_loop_voltage_sequencer");
        else
            $display("FAIL open_loop_voltage_sequencer");
        $finish;
    end

endmodule
